@@ rtl/yuv422_to_rgb_converter_assert.svh @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter assertion macros
// Concurrent checks on the converter's own logic, stubbed out for synthesis.
// ---------------------------------------------------------------------------
`ifndef YUV422_TO_RGB_CONVERTER_ASSERT_SVH
`define YUV422_TO_RGB_CONVERTER_ASSERT_SVH

`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define YRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that, once seen, must be followed by another in the next cycle.
`define YRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define YRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define YRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/yrc_pkg.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB converter package
// Stage payload types and the fixed colour matrix coefficients.
// ---------------------------------------------------------------------------
package yrc_pkg;

    localparam logic BYTE_ORDER_YUYV = 1'b0;
    localparam logic BYTE_ORDER_UYVY = 1'b1;

    localparam logic [8:0] CHROMA_OFFSET = 9'd128;

    localparam logic signed [9:0] COEF_RV = 10'sd359;
    localparam logic signed [9:0] COEF_GU = 10'sd88;
    localparam logic signed [9:0] COEF_GV = 10'sd183;
    localparam logic signed [9:0] COEF_BU = 10'sd454;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    // Luma and centred chroma of one macropixel.
    typedef struct packed {
        logic [7:0]        luma0;
        logic [7:0]        luma1;
        logic signed [8:0] cu;
        logic signed [8:0] cv;
        logic              last;
    } unpack_t;

    // Chroma contributions shared by both pixels.
    typedef struct packed {
        logic [7:0]         luma0;
        logic [7:0]         luma1;
        logic signed [16:0] rv;
        logic signed [16:0] gc;
        logic signed [16:0] bu;
        logic               last;
    } chroma_t;

    // Unscaled channel sums, 256 times the final value.
    typedef struct packed {
        logic signed [17:0] r0;
        logic signed [17:0] g0;
        logic signed [17:0] b0;
        logic signed [17:0] r1;
        logic signed [17:0] g1;
        logic signed [17:0] b1;
        logic               last;
    } sum_t;

endpackage

@@ rtl/yrc_unpack.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 unpack stage
// Sorts the macropixel bytes by byte order and centres the chroma samples.
// ---------------------------------------------------------------------------
`include "yuv422_to_rgb_converter_assert.svh"

module yrc_unpack (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_order,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [31:0]      in_data,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output yrc_pkg::unpack_t out_data
);

    logic             valid_reg;
    yrc_pkg::unpack_t data_reg;
    yrc_pkg::unpack_t data_next;
    logic [7:0]       chroma_u;
    logic [7:0]       chroma_v;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        if (byte_order == yrc_pkg::BYTE_ORDER_UYVY) begin
            chroma_u        = in_data[7:0];
            data_next.luma0 = in_data[15:8];
            chroma_v        = in_data[23:16];
            data_next.luma1 = in_data[31:24];
        end else begin
            data_next.luma0 = in_data[7:0];
            chroma_u        = in_data[15:8];
            data_next.luma1 = in_data[23:16];
            chroma_v        = in_data[31:24];
        end
        // The nine-bit difference is read back as a signed value.
        data_next.cu   = {1'b0, chroma_u} - yrc_pkg::CHROMA_OFFSET;
        data_next.cv   = {1'b0, chroma_v} - yrc_pkg::CHROMA_OFFSET;
        data_next.last = in_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    `YRC_ASSERT_NEXT(a_yuyv_luma0, aclk, aresetn,
        in_valid && in_ready && (byte_order == yrc_pkg::BYTE_ORDER_YUYV),
        out_data.luma0 == $past(in_data[7:0]), "YUYV luma0 not taken from first byte")

endmodule

@@ rtl/yrc_chroma.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 chroma product stage
// Forms the chroma terms of the colour matrix once for both pixels.
// ---------------------------------------------------------------------------
module yrc_chroma (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  yrc_pkg::unpack_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output yrc_pkg::chroma_t out_data
);

    logic               valid_reg;
    yrc_pkg::chroma_t   data_reg;
    yrc_pkg::chroma_t   data_next;
    logic signed [18:0] prod_rv;
    logic signed [18:0] prod_gu;
    logic signed [18:0] prod_gv;
    logic signed [18:0] prod_bu;
    logic signed [18:0] sum_g;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        prod_rv = in_data.cv * yrc_pkg::COEF_RV;
        prod_gu = in_data.cu * yrc_pkg::COEF_GU;
        prod_gv = in_data.cv * yrc_pkg::COEF_GV;
        prod_bu = in_data.cu * yrc_pkg::COEF_BU;
        sum_g   = prod_gu + prod_gv;
        // Every term fits in seventeen signed bits for nine-bit chroma.
        data_next.luma0 = in_data.luma0;
        data_next.luma1 = in_data.luma1;
        data_next.rv    = prod_rv[16:0];
        data_next.gc    = sum_g[16:0];
        data_next.bu    = prod_bu[16:0];
        data_next.last  = in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/yrc_matrix.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 matrix sum stage
// Adds the scaled luma of each pixel to the shared chroma terms.
// ---------------------------------------------------------------------------
module yrc_matrix (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  yrc_pkg::chroma_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output yrc_pkg::sum_t    out_data
);

    logic               valid_reg;
    yrc_pkg::sum_t      data_reg;
    yrc_pkg::sum_t      data_next;
    logic signed [17:0] base0;
    logic signed [17:0] base1;
    logic signed [17:0] rv_ext;
    logic signed [17:0] gc_ext;
    logic signed [17:0] bu_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        base0  = {2'b00, in_data.luma0, 8'h00};
        base1  = {2'b00, in_data.luma1, 8'h00};
        rv_ext = {in_data.rv[16], in_data.rv};
        gc_ext = {in_data.gc[16], in_data.gc};
        bu_ext = {in_data.bu[16], in_data.bu};
        data_next.r0   = base0 + rv_ext;
        data_next.g0   = base0 - gc_ext;
        data_next.b0   = base0 + bu_ext;
        data_next.r1   = base1 + rv_ext;
        data_next.g1   = base1 - gc_ext;
        data_next.b1   = base1 + bu_ext;
        data_next.last = in_data.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

@@ rtl/yrc_clamp.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 scale and clamp stage
// Divides each channel sum by 256 with floor and clamps it to a byte; this
// stage is also the output register of the converter.
// ---------------------------------------------------------------------------
`include "yuv422_to_rgb_converter_assert.svh"

module yrc_clamp (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  yrc_pkg::sum_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [47:0]   out_data,
    output logic          out_last
);

    logic        valid_reg;
    logic [47:0] data_reg;
    logic [47:0] data_next;
    logic        last_reg;

    // A negative sum gives zero; a sum of 65536 or more gives full scale.
    function automatic logic [7:0] scale_clamp(input logic signed [17:0] s);
        logic [7:0] q;
        if (s[17]) begin
            q = 8'd0;
        end else if (s[16]) begin
            q = yrc_pkg::CHAN_MAX;
        end else begin
            q = s[15:8];
        end
        return q;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

    always_comb begin
        data_next[7:0]   = scale_clamp(in_data.r0);
        data_next[15:8]  = scale_clamp(in_data.g0);
        data_next[23:16] = scale_clamp(in_data.b0);
        data_next[31:24] = scale_clamp(in_data.r1);
        data_next[39:32] = scale_clamp(in_data.g1);
        data_next[47:40] = scale_clamp(in_data.b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
            last_reg <= in_data.last;
        end
    end

    `YRC_ASSERT_NEXT(a_red0_floor, aclk, aresetn,
        in_valid && in_ready && in_data.r0[17],
        out_data[7:0] == 8'd0, "negative red sum not clamped to zero")
    `YRC_ASSERT_NEXT(a_blue1_ceiling, aclk, aresetn,
        in_valid && in_ready && !in_data.b1[17] && in_data.b1[16],
        out_data[47:40] == yrc_pkg::CHAN_MAX, "large blue sum not clamped to full scale")

endmodule

@@ rtl/yuv422_to_rgb_converter.sv @@
// ---------------------------------------------------------------------------
// YUV 4:2:2 to RGB888 converter
// Turns one packed macropixel per item into two RGB888 pixels.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one macropixel per item, four bytes in stream
//   order in s_tdata, with s_tlast marking the final macropixel of a frame.
//   The output stream carries the two resulting pixels in m_tdata and a copy
//   of the frame end flag in m_tlast.
//   The byte order register is written through cfg_valid, cfg_ready and
//   cfg_data while the stream is idle: 0 selects Y0 U Y1 V, 1 selects
//   U Y0 V Y1. The port always accepts a write.
//   From input acceptance to m_tvalid an item passes through the unpack,
//   chroma product, matrix sum and clamp registers. One item is
//   accepted per cycle for as long as the receiver takes results.
//   When the receiver stalls, items stay in their stages and empty stages
//   keep filling, so up to four items are held before s_tready falls.
//   Reset empties the pipeline and sets the byte order to Y0 U Y1 V.
// ---------------------------------------------------------------------------
`include "yuv422_to_rgb_converter_assert.svh"

module yuv422_to_rgb_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,     // byte_order
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,      // byte0, byte1, byte2, byte3
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,      // red0, green0, blue0, red1, green1, blue1
    output logic        m_tlast
);

    logic             byte_order_reg;
    logic             unp_valid;
    logic             unp_ready;
    yrc_pkg::unpack_t unp_data;
    logic             chr_valid;
    logic             chr_ready;
    yrc_pkg::chroma_t chr_data;
    logic             mtx_valid;
    logic             mtx_ready;
    yrc_pkg::sum_t    mtx_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg <= yrc_pkg::BYTE_ORDER_YUYV;
        end else if (cfg_valid && cfg_ready) begin
            byte_order_reg <= cfg_data;
        end
    end

    yrc_unpack u_unpack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_order (byte_order_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (unp_valid),
        .out_ready  (unp_ready),
        .out_data   (unp_data)
    );

    yrc_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (unp_valid),
        .in_ready  (unp_ready),
        .in_data   (unp_data),
        .out_valid (chr_valid),
        .out_ready (chr_ready),
        .out_data  (chr_data)
    );

    yrc_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chr_valid),
        .in_ready  (chr_ready),
        .in_data   (chr_data),
        .out_valid (mtx_valid),
        .out_ready (mtx_ready),
        .out_data  (mtx_data)
    );

    yrc_clamp u_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mtx_valid),
        .in_ready  (mtx_ready),
        .in_data   (mtx_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

    // The input may only be refused when every stage holds an item.
    `YRC_ASSERT(a_refuse_only_full, aclk, aresetn,
        !s_tready |-> (unp_valid && chr_valid && mtx_valid && m_tvalid && !m_tready),
        "input refused while the pipeline has room")

endmodule
